// ----- design/print_command_line_decoder_assert.svh -----
// ----------------------------------------------------------------------------
// print command line decoder assertion macros
// shared assertion forms for the decoder checkers
// ----------------------------------------------------------------------------
`ifndef PRINT_COMMAND_LINE_DECODER_ASSERT_SVH
`define PRINT_COMMAND_LINE_DECODER_ASSERT_SVH

// implication checked on every clock edge outside reset
`define PCLD_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// implication whose consequent is checked in the cycle after the antecedent
`define PCLD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/pcld_pkg.sv -----
// ----------------------------------------------------------------------------
// pcld_pkg
// types and constants of the print command line decoder
// ----------------------------------------------------------------------------
`default_nettype none

package pcld_pkg;

  localparam int MAX_LINE_DOTS = 576;
  localparam int DOT_CNT_W     = 11;
  localparam int LINE_LEN_W    = 10;
  localparam int CFG_DATA_W    = 10;
  localparam logic [LINE_LEN_W-1:0] LINE_LEN_RESET = 10'd576;

  localparam logic [7:0] DENSITY_MIN_LOW  = 8'd96;
  localparam logic [7:0] DENSITY_MIN_HIGH = 8'd45;

  localparam logic [31:0] HDR_SPEED   = 32'h40534d53;
  localparam logic [31:0] HDR_DENSITY = 32'h40537e7e;
  localparam logic [31:0] HDR_PAPER   = 32'h40535050;
  localparam logic [15:0] HDR_PAGE_START = 16'h403c;
  localparam logic [15:0] HDR_LINE_START = 16'h233c;
  localparam logic [15:0] HDR_LINE_END   = 16'h233e;
  localparam logic [15:0] HDR_PAGE_END   = 16'h403e;

  localparam logic CFG_STROBE_LOW = 1'b0;
  localparam logic CFG_LINE_LEN   = 1'b1;

  typedef enum logic [2:0] {
    KIND_SPEED      = 3'd0,
    KIND_DENSITY    = 3'd1,
    KIND_PAPER      = 3'd2,
    KIND_PAGE_START = 3'd3,
    KIND_PAGE_END   = 3'd4,
    KIND_LINE_WORD  = 3'd5
  } kind_e;

  typedef enum logic [2:0] {
    MODE_IDLE     = 3'd0,
    MODE_SPEED_HI = 3'd1,
    MODE_SPEED_LO = 3'd2,
    MODE_DENSITY  = 3'd3,
    MODE_PAPER    = 3'd4,
    MODE_LINE     = 3'd5
  } mode_e;

endpackage

`default_nettype wire

// ----- design/print_command_line_decoder.sv -----
// a request's result is registered in the output register as it is accepted
// throughput: one byte per cycle, and one line word per cycle, while no stall
// holds them; a finished line holds the input stalled for its remaining words
// the output register frees as its result is taken, so a new byte enters then
// reset clears parse state, counters, line store and configuration to defaults
// ----------------------------------------------------------------------------
// print_command_line_decoder
// printer command byte stream decoder: headers, settings and run-length lines
// ----------------------------------------------------------------------------
`default_nettype none

module print_command_line_decoder #(
  parameter int MAX_LINE_DOTS = pcld_pkg::MAX_LINE_DOTS
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_index_i,
  input  wire logic [pcld_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  data_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [2:0]       kind_o,
  output logic [15:0]      setting_value_o,
  output logic [15:0]      page_number_o,
  output logic [15:0]      line_number_o,
  output logic [63:0]      dot_word_o,
  output logic [3:0]       word_index_o,
  output logic             last_o
);

  localparam int LINE_WORDS = (MAX_LINE_DOTS + 63) / 64;
  localparam int CNT_W      = (LINE_WORDS > 1) ? $clog2(LINE_WORDS) : 1;
  localparam int POS_W      = pcld_pkg::DOT_CNT_W + 1;
  localparam logic [CNT_W-1:0] LAST_WORD = CNT_W'(LINE_WORDS - 1);
  localparam logic [POS_W-1:0] MAX_POS   = POS_W'(MAX_LINE_DOTS);

  pcld_pkg::mode_e mode_q, mode_d;
  logic [23:0] win_q, win_d;
  logic [7:0]  hi_q, hi_d;
  logic        run_pend_q, run_pend_d;
  logic        run_val_q, run_val_d;
  logic [pcld_pkg::DOT_CNT_W-1:0] dot_q, dot_d;
  logic [63:0] store_q [LINE_WORDS];
  logic [63:0] store_d [LINE_WORDS];
  logic [15:0] page_q, page_d;
  logic [15:0] line_q, line_d;
  logic        strobe_q;
  logic [pcld_pkg::LINE_LEN_W-1:0] len_q;

  logic        burst_q, burst_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic        out_valid_q, out_valid_d;
  pcld_pkg::kind_e kind_q, kind_d;
  logic [15:0] setval_q, setval_d;
  logic [15:0] opage_q, opage_d;
  logic [15:0] oline_q, oline_d;
  logic [63:0] word_q, word_d;
  logic [3:0]  widx_q, widx_d;
  logic        last_q, last_d;

  logic        acc, out_adv;
  logic        fill_go, fill_val;
  logic [8:0]  fill_len;
  logic [POS_W-1:0] fill_lo, fill_hi;
  logic [63:0] fill_mask [LINE_WORDS];
  logic        res_vld, line_done;
  pcld_pkg::kind_e res_kind;
  logic [15:0] res_val;
  logic [31:0] win_cmp;
  logic [7:0]  dens;

  assign in_stall_o = burst_q || (out_valid_q && out_stall_i);
  assign acc        = in_valid_i && !in_stall_o;
  assign out_adv    = !out_valid_q || !out_stall_i;

  // dot span written by this byte
  assign fill_go  = acc && (mode_q == pcld_pkg::MODE_LINE) && (run_pend_q || !data_byte_i[7]);
  assign fill_len = run_pend_q ? ({1'b0, data_byte_i} + 9'd1) : 9'd1;
  assign fill_val = run_pend_q ? run_val_q : (|data_byte_i[6:0]);
  assign fill_lo  = {1'b0, dot_q};
  always_comb begin
    fill_hi = fill_lo + POS_W'(fill_len);
    if (fill_hi > MAX_POS) fill_hi = MAX_POS;
  end

  function automatic logic [6:0] rel_pos(logic [POS_W-1:0] x, logic [POS_W-1:0] base);
    logic [POS_W-1:0] diff;
    diff = x - base;
    if (x <= base) return 7'd0;
    else if (diff >= POS_W'(64)) return 7'd64;
    else return 7'(diff);
  endfunction

  // per word range mask, first dot in bit 63
  always_comb begin
    for (int w = 0; w < LINE_WORDS; w++) begin
      fill_mask[w] = ({64{1'b1}} >> rel_pos(fill_lo, POS_W'(w * 64)))
                   & ~({64{1'b1}} >> rel_pos(fill_hi, POS_W'(w * 64)));
    end
  end

  assign win_cmp = {win_q, data_byte_i};
  assign dens = strobe_q
              ? ((data_byte_i < pcld_pkg::DENSITY_MIN_LOW) ? pcld_pkg::DENSITY_MIN_LOW
                                                           : data_byte_i)
              : ((data_byte_i < pcld_pkg::DENSITY_MIN_HIGH) ? pcld_pkg::DENSITY_MIN_HIGH
                                                            : data_byte_i);

  always_comb begin
    mode_d     = mode_q;
    win_d      = win_q;
    hi_d       = hi_q;
    run_pend_d = run_pend_q;
    run_val_d  = run_val_q;
    dot_d      = dot_q;
    store_d    = store_q;
    page_d     = page_q;
    line_d     = line_q;
    res_vld    = 1'b0;
    res_kind   = pcld_pkg::KIND_SPEED;
    res_val    = 16'd0;
    line_done  = 1'b0;
    if (fill_go && fill_val) begin
      for (int w = 0; w < LINE_WORDS; w++) store_d[w] = store_q[w] | fill_mask[w];
    end
    if (acc) begin
      case (mode_q)
        pcld_pkg::MODE_SPEED_HI: begin
          hi_d   = data_byte_i;
          mode_d = pcld_pkg::MODE_SPEED_LO;
        end
        pcld_pkg::MODE_SPEED_LO: begin
          res_vld = 1'b1;
          res_kind = pcld_pkg::KIND_SPEED;
          res_val = {hi_q, data_byte_i};
          mode_d  = pcld_pkg::MODE_IDLE;
        end
        pcld_pkg::MODE_DENSITY: begin
          res_vld = 1'b1;
          res_kind = pcld_pkg::KIND_DENSITY;
          res_val = {8'd0, dens};
          mode_d  = pcld_pkg::MODE_IDLE;
        end
        pcld_pkg::MODE_PAPER: begin
          res_vld = 1'b1;
          res_kind = pcld_pkg::KIND_PAPER;
          res_val = {8'd0, data_byte_i};
          mode_d  = pcld_pkg::MODE_IDLE;
        end
        pcld_pkg::MODE_LINE: begin
          if (!run_pend_q && data_byte_i[7]) begin
            run_pend_d = 1'b1;
            run_val_d  = |data_byte_i[6:0];
          end else begin
            run_pend_d = 1'b0;
            dot_d = dot_q + pcld_pkg::DOT_CNT_W'(fill_len);
            if (dot_d >= {1'b0, len_q}) begin
              line_done = 1'b1;
              line_d = line_q + 16'd1;
              mode_d = pcld_pkg::MODE_IDLE;
              win_d  = 24'd0;
            end
          end
        end
        default: begin
          mode_d = pcld_pkg::MODE_IDLE;
          win_d  = win_cmp[23:0];
          if (win_cmp == pcld_pkg::HDR_SPEED) begin
            win_d = 24'd0;
            mode_d = pcld_pkg::MODE_SPEED_HI;
          end else if (win_cmp == pcld_pkg::HDR_DENSITY) begin
            win_d = 24'd0;
            mode_d = pcld_pkg::MODE_DENSITY;
          end else if (win_cmp == pcld_pkg::HDR_PAPER) begin
            win_d = 24'd0;
            mode_d = pcld_pkg::MODE_PAPER;
          end else if (win_cmp[15:0] == pcld_pkg::HDR_PAGE_START) begin
            win_d = 24'd0;
            line_d = 16'd0;
            res_vld = 1'b1;
            res_kind = pcld_pkg::KIND_PAGE_START;
          end else if (win_cmp[15:0] == pcld_pkg::HDR_LINE_START) begin
            win_d = 24'd0;
            mode_d = pcld_pkg::MODE_LINE;
            dot_d = '0;
            run_pend_d = 1'b0;
            run_val_d = 1'b0;
            for (int w = 0; w < LINE_WORDS; w++) store_d[w] = 64'd0;
          end else if (win_cmp[15:0] == pcld_pkg::HDR_LINE_END) begin
            win_d = 24'd0;
          end else if (win_cmp[15:0] == pcld_pkg::HDR_PAGE_END) begin
            win_d = 24'd0;
            page_d = page_q + 16'd1;
            res_vld = 1'b1;
            res_kind = pcld_pkg::KIND_PAGE_END;
          end
        end
      endcase
    end
  end

  // output register and line word sequencer
  always_comb begin
    burst_d     = burst_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q;
    kind_d      = kind_q;
    setval_d    = setval_q;
    opage_d     = opage_q;
    oline_d     = oline_q;
    word_d      = word_q;
    widx_d      = widx_q;
    last_d      = last_q;
    if (out_adv) begin
      if (burst_q) begin
        out_valid_d = 1'b1;
        kind_d   = pcld_pkg::KIND_LINE_WORD;
        setval_d = 16'd0;
        opage_d  = page_q;
        oline_d  = line_q;
        word_d   = store_q[cnt_q];
        widx_d   = 4'(cnt_q);
        last_d   = (cnt_q == LAST_WORD);
        burst_d  = (cnt_q != LAST_WORD);
        cnt_d    = cnt_q + CNT_W'(1);
      end else if (line_done) begin
        out_valid_d = 1'b1;
        kind_d   = pcld_pkg::KIND_LINE_WORD;
        setval_d = 16'd0;
        opage_d  = page_d;
        oline_d  = line_d;
        word_d   = store_d[0];
        widx_d   = 4'd0;
        last_d   = (LINE_WORDS == 1);
        burst_d  = (LINE_WORDS > 1);
        cnt_d    = CNT_W'(1);
      end else if (res_vld) begin
        out_valid_d = 1'b1;
        kind_d   = res_kind;
        setval_d = res_val;
        opage_d  = page_d;
        oline_d  = line_d;
        word_d   = 64'd0;
        widx_d   = 4'd0;
        last_d   = 1'b1;
      end else begin
        out_valid_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= pcld_pkg::MODE_IDLE;
      win_q       <= 24'd0;
      hi_q        <= 8'd0;
      run_pend_q  <= 1'b0;
      run_val_q   <= 1'b0;
      dot_q       <= '0;
      page_q      <= 16'd0;
      line_q      <= 16'd0;
      strobe_q    <= 1'b0;
      len_q       <= pcld_pkg::LINE_LEN_RESET;
      burst_q     <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      for (int w = 0; w < LINE_WORDS; w++) store_q[w] <= 64'd0;
    end else begin
      mode_q      <= mode_d;
      win_q       <= win_d;
      hi_q        <= hi_d;
      run_pend_q  <= run_pend_d;
      run_val_q   <= run_val_d;
      dot_q       <= dot_d;
      page_q      <= page_d;
      line_q      <= line_d;
      burst_q     <= burst_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
      store_q     <= store_d;
      if (cfg_we_i) begin
        case (cfg_index_i)
          pcld_pkg::CFG_STROBE_LOW: strobe_q <= cfg_wdata_i[0];
          pcld_pkg::CFG_LINE_LEN:   len_q    <= cfg_wdata_i[pcld_pkg::LINE_LEN_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q   <= kind_d;
    setval_q <= setval_d;
    opage_q  <= opage_d;
    oline_q  <= oline_d;
    word_q   <= word_d;
    widx_q   <= widx_d;
    last_q   <= last_d;
  end

  assign out_valid_o     = out_valid_q;
  assign kind_o          = kind_q;
  assign setting_value_o = setval_q;
  assign page_number_o   = opage_q;
  assign line_number_o   = oline_q;
  assign dot_word_o      = word_q;
  assign word_index_o    = widx_q;
  assign last_o          = last_q;

endmodule

`default_nettype wire

// ----- design/pcld_checker.sv -----
// ----------------------------------------------------------------------------
// pcld_checker
// port level checks of the print command line decoder
// ----------------------------------------------------------------------------
`default_nettype none

`include "print_command_line_decoder_assert.svh"

module pcld_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        out_valid_o,
  input wire logic        out_stall_i,
  input wire logic [2:0]  kind_o,
  input wire logic [63:0] dot_word_o,
  input wire logic [3:0]  word_index_o,
  input wire logic        last_o
);

  // a held result stays up
  `PCLD_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o, "result dropped")

  // only line words carry dots or a word position
  `PCLD_ASSERT_IMP(a_word_fields,
    out_valid_o && (kind_o != pcld_pkg::KIND_LINE_WORD),
    (dot_word_o == 64'd0) && (word_index_o == 4'd0) && last_o, "stray line fields")

  // a line word that is not last is followed by the next word of the line
  `PCLD_ASSERT_NEXT(a_word_seq,
    out_valid_o && !out_stall_i && (kind_o == pcld_pkg::KIND_LINE_WORD) && !last_o,
    out_valid_o && (kind_o == pcld_pkg::KIND_LINE_WORD)
      && (word_index_o == $past(word_index_o) + 4'd1), "line word sequence broken")

  // setting and page results never carry a nonzero word index
  `PCLD_ASSERT_IMP(a_word_first, out_valid_o && (word_index_o != 4'd0),
    kind_o == pcld_pkg::KIND_LINE_WORD, "word index on non line result")

endmodule

bind print_command_line_decoder pcld_checker u_pcld_checker (.*);

`default_nettype wire
